// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent check macros, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FFHA_CHECK(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("ffha check failed");
`define FFHA_CHECK_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ffha check failed");
`else
`define FFHA_CHECK(lbl, clk, rst_n, expr)
`define FFHA_CHECK_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: design/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// constants and types of the first-fit heap allocator
// ----------------------------------------------------------------------------
`default_nettype none
package ffha_pkg;
    localparam int HEAP_BYTES   = 4096;
    localparam int HEADER_BYTES = 32;
    localparam int FOOTER_BYTES = 8;
    localparam int AW           = $clog2(HEAP_BYTES);
    localparam int LW           = AW + 1;

    localparam logic [AW-1:0] HDR   = AW'(HEADER_BYTES);
    localparam logic [AW-1:0] FTR   = AW'(FOOTER_BYTES);
    localparam logic [LW-1:0] OVH   = LW'(HEADER_BYTES + FOOTER_BYTES);
    localparam logic [LW-1:0] NULLP = LW'(HEAP_BYTES);

    localparam logic [1:0] REQ_ALLOC   = 2'd0;
    localparam logic [1:0] REQ_FREE    = 2'd1;
    localparam logic [1:0] REQ_REALLOC = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OOM  = 2'd1;
    localparam logic [1:0] ST_NULL = 2'd2;

    // one store write per cycle
    typedef struct packed {
        logic          sz;
        logic          used;
        logic          nxt;
        logic          prv;
        logic          ft;
        logic [AW-1:0] addr;
        logic [LW-1:0] data;
    } t_wr;
endpackage
`default_nettype wire

// File: design/first_fit_heap_allocator_unit.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit
// boundary-tag heap allocator with a lifo explicit free list, first fit
// ----------------------------------------------------------------------------
// One word is taken at a time; o_stall stays high until its result word has
// been taken. Block headers (size, used, next, prev) and footers live in
// single-port stores with registered reads: each read sets the address and
// passes a wait state before its data is used, and a sequencer issues at most
// one store write per cycle. An allocate walks the free list node by node,
// then grows the heap or carves the chosen block; a moved reallocate adds a
// free to an allocate. The stores need no clearing pass after reset.
// heap_limit is written through the cfg port, always ready; the user must
// write it only while the block is idle, as the block does not enforce this.
`default_nettype none
`include "assert_macros.svh"
module first_fit_heap_allocator_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [11:0] i_req_size,
    input  wire logic [11:0] i_addr,
    input  wire logic        i_has_addr,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic [11:0]      o_result_addr,
    output logic [11:0]      o_copy_src,
    output logic [11:0]      o_copy_len,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [12:0] i_cfg_data
);
    localparam int AW = ffha_pkg::AW;
    localparam int LW = ffha_pkg::LW;
    localparam int NS = 55;

    typedef enum logic [NS-1:0] {
        S_IDLE    = NS'(1) << 0,  S_DISP    = NS'(1) << 1,  S_RWAIT   = NS'(1) << 2,
        S_REA_CHK = NS'(1) << 3,  S_REA_SHR = NS'(1) << 4,  S_REA_GRB = NS'(1) << 5,
        S_REA_MOV = NS'(1) << 6,  S_ALC_END = NS'(1) << 7,  S_OUT     = NS'(1) << 8,
        S_GR_LOOP = NS'(1) << 9,  S_GR_TEST = NS'(1) << 10, S_GR_FIT  = NS'(1) << 11,
        S_GR_GROW = NS'(1) << 12, S_GR_W1   = NS'(1) << 13, S_GR_W2   = NS'(1) << 14,
        S_GR_W3   = NS'(1) << 15, S_GR_W4   = NS'(1) << 16, S_CV_START= NS'(1) << 17,
        S_CV_RD   = NS'(1) << 18, S_CV_W1   = NS'(1) << 19, S_CV_W2   = NS'(1) << 20,
        S_CV_W3   = NS'(1) << 21, S_CV_W4   = NS'(1) << 22, S_CV_L1   = NS'(1) << 23,
        S_CV_L2   = NS'(1) << 24, S_CV_L3   = NS'(1) << 25, S_CV_L4   = NS'(1) << 26,
        S_CV_L5   = NS'(1) << 27, S_CV_L6   = NS'(1) << 28, S_CV_L7   = NS'(1) << 29,
        S_CV_L8   = NS'(1) << 30, S_UN_START= NS'(1) << 31, S_UN_RD   = NS'(1) << 32,
        S_UN_W1   = NS'(1) << 33, S_UN_W2   = NS'(1) << 34, S_UN_W3   = NS'(1) << 35,
        S_UN_H1   = NS'(1) << 36, S_UN_N1   = NS'(1) << 37, S_UN_N2   = NS'(1) << 38,
        S_PU_W1   = NS'(1) << 39, S_PU_W2   = NS'(1) << 40, S_PU_W3   = NS'(1) << 41,
        S_PU_W4   = NS'(1) << 42, S_RL_START= NS'(1) << 43, S_RL_FT   = NS'(1) << 44,
        S_RL_LU   = NS'(1) << 45, S_RL_LM1  = NS'(1) << 46, S_RL_LM2  = NS'(1) << 47,
        S_RL_LM3  = NS'(1) << 48, S_RL_RIGHT= NS'(1) << 49, S_RL_R1   = NS'(1) << 50,
        S_RL_R2   = NS'(1) << 51, S_RL_R3   = NS'(1) << 52, S_RL_R4   = NS'(1) << 53,
        S_RL_R5   = NS'(1) << 54
    } t_state;

    // stores
    logic [AW-1:0] m_size [ffha_pkg::HEAP_BYTES];
    logic          m_used [ffha_pkg::HEAP_BYTES];
    logic [LW-1:0] m_next [ffha_pkg::HEAP_BYTES];
    logic [LW-1:0] m_prev [ffha_pkg::HEAP_BYTES];
    logic [AW-1:0] m_foot [ffha_pkg::HEAP_BYTES];
    logic [AW-1:0] q_size, q_foot;
    logic          q_used;
    logic [LW-1:0] q_next, q_prev;

    t_state r_state, n_state, r_ret, n_ret;
    t_state r_kgr, n_kgr, r_kcv, n_kcv, r_kun, n_kun, r_kpu, n_kpu, r_krl, n_krl;
    logic [LW-1:0] r_fh, n_fh, r_top, n_top, r_lim;
    logic [1:0]    r_type, n_type;
    logic [AW-1:0] r_s, n_s, r_a, n_a, r_p, n_p;
    logic          r_has, n_has, r_ok, n_ok, r_cused, n_cused;
    logic [AW-1:0] r_ra, n_ra, r_fa, n_fa;
    logic [LW-1:0] r_cur, n_cur, r_steps, n_steps, r_nx, n_nx, r_pr, n_pr;
    logic [AW-1:0] r_h, n_h, r_old, n_old, r_cx, n_cx, r_q, n_q, r_rest, n_rest;
    logic [AW-1:0] r_ux, n_ux, r_px, n_px, r_ls, n_ls, r_bsp, n_bsp, r_rr, n_rr;
    logic [AW-1:0] r_nsz, n_nsz;
    logic [1:0]    r_st, n_st;
    logic [AW-1:0] r_res, n_res, r_src, n_src, r_len, n_len;
    ffha_pkg::t_wr w;

    logic [LW-1:0]   lim;
    logic [LW:0]     grow_end, rgt_end;
    logic [LW-1:0]   s_ovh;
    logic            req_valid;
    logic [AW-1:0]   a_base;

    assign lim       = (r_lim > ffha_pkg::NULLP) ? ffha_pkg::NULLP : r_lim;
    assign s_ovh     = {1'b0, r_s} + ffha_pkg::OVH;
    assign grow_end  = {1'b0, r_top} + {1'b0, s_ovh};
    assign rgt_end   = {2'b00, r_p} + {2'b00, q_size} + {1'b0, ffha_pkg::OVH};
    assign a_base    = r_a - ffha_pkg::HDR;
    assign req_valid = r_has && (r_a >= ffha_pkg::HDR) && ({1'b0, a_base} < r_top);

    always_ff @(posedge i_clk) begin
        if (w.sz)   m_size[w.addr] <= w.data[AW-1:0];
        if (w.used) m_used[w.addr] <= w.data[0];
        if (w.nxt)  m_next[w.addr] <= w.data;
        if (w.prv)  m_prev[w.addr] <= w.data;
        if (w.ft)   m_foot[w.addr] <= w.data[AW-1:0];
        q_size <= m_size[r_ra];
        q_used <= m_used[r_ra];
        q_next <= m_next[r_ra];
        q_prev <= m_prev[r_ra];
        q_foot <= m_foot[r_fa];
    end

    always_comb begin
        n_state = r_state; n_ret = r_ret;
        n_kgr = r_kgr; n_kcv = r_kcv; n_kun = r_kun; n_kpu = r_kpu; n_krl = r_krl;
        n_fh = r_fh; n_top = r_top;
        n_type = r_type; n_s = r_s; n_a = r_a; n_p = r_p; n_has = r_has;
        n_ok = r_ok; n_cused = r_cused; n_ra = r_ra; n_fa = r_fa;
        n_cur = r_cur; n_steps = r_steps; n_nx = r_nx; n_pr = r_pr;
        n_h = r_h; n_old = r_old; n_cx = r_cx; n_q = r_q; n_rest = r_rest;
        n_ux = r_ux; n_px = r_px; n_ls = r_ls; n_bsp = r_bsp; n_rr = r_rr; n_nsz = r_nsz;
        n_st = r_st; n_res = r_res; n_src = r_src; n_len = r_len;
        w = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_type = i_req_type; n_s = i_req_size;
                    n_a = i_addr; n_has = i_has_addr;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_st = ffha_pkg::ST_NULL; n_res = '0; n_src = '0; n_len = '0;
                n_p = a_base;
                n_state = S_OUT;
                if (r_type == ffha_pkg::REQ_ALLOC ||
                    (r_type == ffha_pkg::REQ_REALLOC && !r_has)) begin
                    if (r_s != '0) begin
                        n_cur = r_fh; n_steps = '0; n_kgr = S_ALC_END;
                        n_state = S_GR_LOOP;
                    end
                end else if (r_type == ffha_pkg::REQ_FREE) begin
                    if (req_valid) begin
                        n_krl = S_OUT; n_state = S_RL_START;
                    end
                end else if (r_type == ffha_pkg::REQ_REALLOC && req_valid) begin
                    if (r_s == '0) begin
                        n_krl = S_OUT; n_state = S_RL_START;
                    end else begin
                        n_ra = a_base; n_ret = S_REA_CHK; n_state = S_RWAIT;
                    end
                end
            end
            S_RWAIT: n_state = r_ret;
            S_REA_CHK: begin
                if (q_size >= r_s) begin
                    n_cx = r_p; n_kcv = S_REA_SHR; n_state = S_CV_START;
                end else begin
                    n_old = q_size;
                    n_cur = r_fh; n_steps = '0; n_kgr = S_REA_GRB;
                    n_state = S_GR_LOOP;
                end
            end
            S_REA_SHR: begin
                n_st = ffha_pkg::ST_OK; n_res = r_p + ffha_pkg::HDR; n_state = S_OUT;
            end
            S_REA_GRB: begin
                if (r_ok) begin
                    n_krl = S_REA_MOV; n_state = S_RL_START;
                end else begin
                    n_st = ffha_pkg::ST_OOM; n_state = S_OUT;
                end
            end
            S_REA_MOV: begin
                n_st = ffha_pkg::ST_OK; n_res = r_h + ffha_pkg::HDR;
                n_src = r_a; n_len = r_old; n_state = S_OUT;
            end
            S_ALC_END: begin
                n_st  = r_ok ? ffha_pkg::ST_OK : ffha_pkg::ST_OOM;
                n_res = r_ok ? (r_h + ffha_pkg::HDR) : '0;
                n_state = S_OUT;
            end
            S_OUT: if (!i_stall) n_state = S_IDLE;
            // first-fit walk
            S_GR_LOOP: begin
                if (r_cur[AW] || r_steps[AW]) begin
                    n_state = S_GR_GROW;
                end else begin
                    n_ra = r_cur[AW-1:0]; n_ret = S_GR_TEST; n_state = S_RWAIT;
                end
            end
            S_GR_TEST: begin
                if (q_size >= r_s) begin
                    n_h = r_cur[AW-1:0]; n_cx = r_cur[AW-1:0];
                    n_kcv = S_GR_FIT; n_state = S_CV_START;
                end else begin
                    n_cur = q_next; n_steps = r_steps + 1'b1; n_state = S_GR_LOOP;
                end
            end
            S_GR_FIT: begin
                n_ok = 1'b1; n_state = r_kgr;
            end
            S_GR_GROW: begin
                if (grow_end > {1'b0, lim}) begin
                    n_ok = 1'b0; n_state = r_kgr;
                end else begin
                    n_h = r_top[AW-1:0];
                    w.used = 1'b1; w.addr = r_top[AW-1:0]; w.data = LW'(1);
                    n_state = S_GR_W1;
                end
            end
            S_GR_W1: begin
                w.sz = 1'b1; w.addr = r_h; w.data = {1'b0, r_s}; n_state = S_GR_W2;
            end
            S_GR_W2: begin
                w.nxt = 1'b1; w.addr = r_h; w.data = ffha_pkg::NULLP; n_state = S_GR_W3;
            end
            S_GR_W3: begin
                w.prv = 1'b1; w.addr = r_h; w.data = ffha_pkg::NULLP; n_state = S_GR_W4;
            end
            S_GR_W4: begin
                w.ft = 1'b1; w.addr = r_h + ffha_pkg::HDR + r_s; w.data = {1'b0, r_s};
                n_top = grow_end[LW-1:0];
                n_ok = 1'b1; n_state = r_kgr;
            end
            // shape block to the requested size
            S_CV_START: begin
                n_ra = r_cx; n_ret = S_CV_RD; n_state = S_RWAIT;
            end
            S_CV_RD: begin
                n_cused = q_used; n_nx = q_next; n_pr = q_prev;
                n_rest = q_size - s_ovh[AW-1:0];
                n_q = r_cx + s_ovh[AW-1:0];
                if ({1'b0, q_size} > s_ovh) begin
                    n_state = S_CV_W1;
                end else if (!q_used) begin
                    n_ux = r_cx; n_kun = r_kcv; n_state = S_UN_START;
                end else begin
                    n_state = r_kcv;
                end
            end
            S_CV_W1: begin
                w.sz = 1'b1; w.addr = r_cx; w.data = {1'b0, r_s}; n_state = S_CV_W2;
            end
            S_CV_W2: begin
                w.ft = 1'b1; w.addr = r_cx + ffha_pkg::HDR + r_s; w.data = {1'b0, r_s};
                n_state = S_CV_W3;
            end
            S_CV_W3: begin
                w.sz = 1'b1; w.addr = r_q; w.data = {1'b0, r_rest}; n_state = S_CV_W4;
            end
            S_CV_W4: begin
                w.ft = 1'b1; w.addr = r_q + ffha_pkg::HDR + r_rest; w.data = {1'b0, r_rest};
                if (!r_cused) begin
                    n_state = S_CV_L1;
                end else begin
                    n_px = r_q; n_kpu = r_kcv; n_state = S_PU_W1;
                end
            end
            // remainder takes the chosen block's place on the list
            S_CV_L1: begin
                w.used = 1'b1; w.addr = r_cx; w.data = LW'(1); n_state = S_CV_L2;
            end
            S_CV_L2: begin
                w.nxt = 1'b1; w.addr = r_q; w.data = r_nx; n_state = S_CV_L3;
            end
            S_CV_L3: begin
                w.prv = 1'b1; w.addr = r_q; w.data = r_pr; n_state = S_CV_L4;
            end
            S_CV_L4: begin
                w.prv = (r_nx != ffha_pkg::NULLP); w.addr = r_nx[AW-1:0];
                w.data = {1'b0, r_q}; n_state = S_CV_L5;
            end
            S_CV_L5: begin
                w.nxt = (r_pr != ffha_pkg::NULLP); w.addr = r_pr[AW-1:0];
                w.data = {1'b0, r_q}; n_state = S_CV_L6;
            end
            S_CV_L6: begin
                if (r_fh == {1'b0, r_cx}) n_fh = {1'b0, r_q};
                w.prv = 1'b1; w.addr = r_cx; w.data = ffha_pkg::NULLP; n_state = S_CV_L7;
            end
            S_CV_L7: begin
                w.nxt = 1'b1; w.addr = r_cx; w.data = ffha_pkg::NULLP; n_state = S_CV_L8;
            end
            S_CV_L8: begin
                w.used = 1'b1; w.addr = r_q; w.data = '0; n_state = r_kcv;
            end
            // unlink
            S_UN_START: begin
                n_ra = r_ux; n_ret = S_UN_RD; n_state = S_RWAIT;
            end
            S_UN_RD: begin
                n_pr = q_prev; n_nx = q_next; n_state = S_UN_W1;
            end
            S_UN_W1: begin
                w.used = 1'b1; w.addr = r_ux; w.data = LW'(1); n_state = S_UN_W2;
            end
            S_UN_W2: begin
                w.prv = 1'b1; w.addr = r_ux; w.data = ffha_pkg::NULLP; n_state = S_UN_W3;
            end
            S_UN_W3: begin
                w.nxt = 1'b1; w.addr = r_ux; w.data = ffha_pkg::NULLP;
                if (r_fh == {1'b0, r_ux}) begin
                    n_fh = r_nx; n_state = S_UN_H1;
                end else begin
                    n_state = S_UN_N1;
                end
            end
            S_UN_H1: begin
                w.prv = (r_nx != ffha_pkg::NULLP); w.addr = r_nx[AW-1:0];
                w.data = ffha_pkg::NULLP; n_state = r_kun;
            end
            S_UN_N1: begin
                w.nxt = (r_pr != ffha_pkg::NULLP); w.addr = r_pr[AW-1:0];
                w.data = r_nx; n_state = S_UN_N2;
            end
            S_UN_N2: begin
                w.prv = (r_nx != ffha_pkg::NULLP); w.addr = r_nx[AW-1:0];
                w.data = r_pr; n_state = r_kun;
            end
            // push on the list head
            S_PU_W1: begin
                w.used = 1'b1; w.addr = r_px; w.data = '0; n_state = S_PU_W2;
            end
            S_PU_W2: begin
                w.prv = 1'b1; w.addr = r_px; w.data = ffha_pkg::NULLP; n_state = S_PU_W3;
            end
            S_PU_W3: begin
                w.nxt = 1'b1; w.addr = r_px; w.data = r_fh; n_state = S_PU_W4;
            end
            S_PU_W4: begin
                w.prv = (r_fh != ffha_pkg::NULLP); w.addr = r_fh[AW-1:0];
                w.data = {1'b0, r_px};
                n_fh = {1'b0, r_px}; n_state = r_kpu;
            end
            // release: left merge, else right merge, else push
            S_RL_START: begin
                if (r_p >= ffha_pkg::FTR) begin
                    n_fa = r_p - ffha_pkg::FTR; n_ret = S_RL_FT; n_state = S_RWAIT;
                end else begin
                    n_state = S_RL_RIGHT;
                end
            end
            S_RL_FT: begin
                n_ls = q_foot;
                n_ux = r_p - q_foot - ffha_pkg::OVH[AW-1:0];
                if ({2'b00, r_p} >= ({2'b00, q_foot} + {1'b0, ffha_pkg::OVH})) begin
                    n_ra = r_p - q_foot - ffha_pkg::OVH[AW-1:0];
                    n_ret = S_RL_LU; n_state = S_RWAIT;
                end else begin
                    n_state = S_RL_RIGHT;
                end
            end
            S_RL_LU: begin
                if (!q_used) begin
                    n_kun = S_RL_LM1; n_state = S_UN_START;
                end else begin
                    n_state = S_RL_RIGHT;
                end
            end
            S_RL_LM1: begin
                n_ra = r_p; n_ret = S_RL_LM2; n_state = S_RWAIT;
            end
            S_RL_LM2: begin
                n_nsz = r_ls + ffha_pkg::OVH[AW-1:0] + q_size;
                w.sz = 1'b1; w.addr = r_ux;
                w.data = {1'b0, r_ls + ffha_pkg::OVH[AW-1:0] + q_size};
                n_state = S_RL_LM3;
            end
            S_RL_LM3: begin
                w.ft = 1'b1; w.addr = r_ux + ffha_pkg::HDR + r_nsz; w.data = {1'b0, r_nsz};
                n_px = r_ux; n_kpu = r_krl; n_state = S_PU_W1;
            end
            S_RL_RIGHT: begin
                n_ra = r_p; n_ret = S_RL_R1; n_state = S_RWAIT;
            end
            S_RL_R1: begin
                n_bsp = q_size; n_rr = rgt_end[AW-1:0];
                if (rgt_end < {1'b0, r_top}) begin
                    n_ra = rgt_end[AW-1:0]; n_ret = S_RL_R2; n_state = S_RWAIT;
                end else begin
                    n_px = r_p; n_kpu = r_krl; n_state = S_PU_W1;
                end
            end
            S_RL_R2: begin
                if (!q_used) begin
                    n_ux = r_rr; n_kun = S_RL_R3; n_state = S_UN_START;
                end else begin
                    n_px = r_p; n_kpu = r_krl; n_state = S_PU_W1;
                end
            end
            S_RL_R3: begin
                n_ra = r_rr; n_ret = S_RL_R4; n_state = S_RWAIT;
            end
            S_RL_R4: begin
                n_nsz = r_bsp + ffha_pkg::OVH[AW-1:0] + q_size;
                w.sz = 1'b1; w.addr = r_p;
                w.data = {1'b0, r_bsp + ffha_pkg::OVH[AW-1:0] + q_size};
                n_state = S_RL_R5;
            end
            S_RL_R5: begin
                w.ft = 1'b1; w.addr = r_p + ffha_pkg::HDR + r_nsz; w.data = {1'b0, r_nsz};
                n_px = r_p; n_kpu = r_krl; n_state = S_PU_W1;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fh    <= ffha_pkg::NULLP;
            r_top   <= '0;
            r_lim   <= ffha_pkg::NULLP;
        end else begin
            r_state <= n_state;
            r_fh    <= n_fh;
            r_top   <= n_top;
            if (i_cfg_valid && o_cfg_ready) r_lim <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret <= n_ret; r_kgr <= n_kgr; r_kcv <= n_kcv; r_kun <= n_kun;
        r_kpu <= n_kpu; r_krl <= n_krl;
        r_type <= n_type; r_s <= n_s; r_a <= n_a; r_p <= n_p; r_has <= n_has;
        r_ok <= n_ok; r_cused <= n_cused; r_ra <= n_ra; r_fa <= n_fa;
        r_cur <= n_cur; r_steps <= n_steps; r_nx <= n_nx; r_pr <= n_pr;
        r_h <= n_h; r_old <= n_old; r_cx <= n_cx; r_q <= n_q; r_rest <= n_rest;
        r_ux <= n_ux; r_px <= n_px; r_ls <= n_ls; r_bsp <= n_bsp; r_rr <= n_rr;
        r_nsz <= n_nsz;
        r_st <= n_st; r_res <= n_res; r_src <= n_src; r_len <= n_len;
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_status      = r_st;
    assign o_result_addr = r_res;
    assign o_copy_src    = r_src;
    assign o_copy_len    = r_len;
    assign o_cfg_ready   = 1'b1;

    `FFHA_CHECK(a_top_bound, i_clk, i_rst_n, r_top <= ffha_pkg::NULLP)
    `FFHA_CHECK_NEXT(a_top_grow, i_clk, i_rst_n, r_state != S_GR_W4, $stable(r_top))
    `FFHA_CHECK(a_out_code, i_clk, i_rst_n, !o_valid || (r_st <= ffha_pkg::ST_NULL))
endmodule
`default_nettype wire

// File: bench/tb_first_fit_heap_allocator_unit.sv
// ----------------------------------------------------------------------------
// tb_first_fit_heap_allocator_unit
// allocate, free and reallocate words against a first-fit heap predictor
// ----------------------------------------------------------------------------
// Each request word is predicted on acceptance by a behavioral copy of the
// heap: boundary tags, the lifo free list, splits, merges and growth up to the
// heap limit. Result words are checked in order, field by field. The bench
// keeps a list of live payload addresses. Frees and reallocates name only
// live blocks, bad addresses or null, so no store entry is read before it
// has been written. Both sides idle in random bursts, except in the last
// phase.
`default_nettype none
module tb_first_fit_heap_allocator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  HEAP_BYTES   = ffha_pkg::HEAP_BYTES;
    localparam int  HEADER_BYTES = ffha_pkg::HEADER_BYTES;
    localparam int  FOOTER_BYTES = ffha_pkg::FOOTER_BYTES;
    localparam int  OVER         = HEADER_BYTES + FOOTER_BYTES;
    localparam int  CYCLE_LIMIT  = 3000000;
    localparam int  ITEMS_PHASE  = 150;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] result_addr;
        logic [11:0] copy_src;
        logic [11:0] copy_len;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_req_type = ffha_pkg::REQ_ALLOC;
    logic [11:0] i_req_size = '0;
    logic [11:0] i_addr = '0;
    logic        i_has_addr = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_status;
    logic [11:0] o_result_addr;
    logic [11:0] o_copy_src;
    logic [11:0] o_copy_len;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [12:0] i_cfg_data = '0;

    first_fit_heap_allocator_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_req_type(i_req_type), .i_req_size(i_req_size),
        .i_addr(i_addr), .i_has_addr(i_has_addr),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_status(o_status), .o_result_addr(o_result_addr),
        .o_copy_src(o_copy_src), .o_copy_len(o_copy_len),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    // heap image
    int   hdr_size [HEAP_BYTES];
    bit   hdr_used [HEAP_BYTES];
    int   hdr_next [HEAP_BYTES];
    int   hdr_prev [HEAP_BYTES];
    int   ftr_size [HEAP_BYTES];
    int   list_head = HEAP_BYTES;
    int   heap_top = 0;
    int   heap_limit = 4096;

    t_result  pending_results[$];
    int       live_blocks[$];
    int       mismatches = 0;
    int       cycles = 0;
    bit       quiet = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic report(input string what);
        $display("mismatch at cycle %0d: %s", cycles, what);
        mismatches++;
    endtask

    function automatic int wrap(input int a);
        return a % HEAP_BYTES;
    endfunction

    function automatic void put_footer(input int h, input int sz);
        ftr_size[wrap(h + HEADER_BYTES + sz)] = sz;
    endfunction

    function automatic void unlink_free(input int x);
        int pr;
        int nx;
        pr = hdr_prev[x];
        nx = hdr_next[x];
        hdr_used[x] = 1'b1;
        hdr_prev[x] = HEAP_BYTES;
        hdr_next[x] = HEAP_BYTES;
        if (x == list_head) begin
            list_head = nx;
            if (nx != HEAP_BYTES) hdr_prev[wrap(nx)] = HEAP_BYTES;
            return;
        end
        if (pr != HEAP_BYTES) hdr_next[wrap(pr)] = nx;
        if (nx != HEAP_BYTES) hdr_prev[wrap(nx)] = pr;
    endfunction

    function automatic void push_free(input int x);
        hdr_used[x] = 1'b0;
        hdr_prev[x] = HEAP_BYTES;
        hdr_next[x] = list_head;
        if (list_head != HEAP_BYTES) hdr_prev[wrap(list_head)] = x;
        list_head = x;
    endfunction

    // trim block p to payload s, splitting off the remainder if it is worth it
    function automatic void shape_block(input int s, input int p);
        int old;
        int rest;
        int q;
        int nx;
        int pr;
        old = hdr_size[p];
        if (old > s + OVER) begin
            rest = old - s - OVER;
            q = wrap(p + s + OVER);
            hdr_size[p] = s;
            put_footer(p, s);
            hdr_size[q] = rest;
            put_footer(q, rest);
            if (!hdr_used[p]) begin
                nx = hdr_next[p];
                pr = hdr_prev[p];
                hdr_used[p] = 1'b1;
                hdr_next[q] = nx;
                hdr_prev[q] = pr;
                if (nx != HEAP_BYTES) hdr_prev[wrap(nx)] = q;
                if (pr != HEAP_BYTES) hdr_next[wrap(pr)] = q;
                if (list_head == p) list_head = q;
                hdr_prev[p] = HEAP_BYTES;
                hdr_next[p] = HEAP_BYTES;
                hdr_used[q] = 1'b0;
            end else begin
                push_free(q);
            end
        end else if (!hdr_used[p]) begin
            unlink_free(p);
        end
    endfunction

    // first fit on the list, else grow the top; returns 1 when out of memory
    function automatic bit take_block(input int s, output int h);
        int cur;
        int steps;
        int c;
        int lim;
        cur = list_head;
        steps = 0;
        h = 0;
        while (cur != HEAP_BYTES && steps < HEAP_BYTES) begin
            c = wrap(cur);
            if (hdr_size[c] >= s) begin
                shape_block(s, c);
                h = c;
                return 1'b0;
            end
            cur = hdr_next[c];
            steps++;
        end
        lim = heap_limit < HEAP_BYTES ? heap_limit : HEAP_BYTES;
        if (heap_top + s + OVER > lim) return 1'b1;
        h = wrap(heap_top);
        hdr_used[h] = 1'b1;
        hdr_size[h] = s;
        hdr_next[h] = HEAP_BYTES;
        hdr_prev[h] = HEAP_BYTES;
        put_footer(h, s);
        heap_top += s + OVER;
        return 1'b0;
    endfunction

    function automatic void give_back(input int p);
        int ls;
        int ln;
        int r;
        int nsz;
        if (p != 0 && p >= FOOTER_BYTES) begin
            ls = ftr_size[wrap(p - FOOTER_BYTES)];
            if (p >= ls + OVER) begin
                ln = p - ls - OVER;
                if (!hdr_used[ln]) begin
                    unlink_free(ln);
                    nsz = ls + OVER + hdr_size[p];
                    hdr_size[ln] = nsz;
                    put_footer(ln, nsz);
                    push_free(ln);
                    return;
                end
            end
        end
        r = p + hdr_size[p] + OVER;
        if (r < heap_top && !hdr_used[wrap(r)]) begin
            unlink_free(wrap(r));
            nsz = hdr_size[p] + OVER + hdr_size[wrap(r)];
            hdr_size[p] = nsz;
            put_footer(p, nsz);
            push_free(p);
            return;
        end
        push_free(p);
    endfunction

    function automatic t_result heap_response(input logic [1:0] kind, input int s,
                                              input int a, input bit has);
        t_result res;
        bit      ok_addr;
        int      p;
        int      h;
        int      old;
        res = '{status: ffha_pkg::ST_NULL, default: '0};
        ok_addr = has && a >= HEADER_BYTES && (a - HEADER_BYTES) < heap_top;
        p = ok_addr ? wrap(a - HEADER_BYTES) : 0;
        if (kind == ffha_pkg::REQ_ALLOC || (kind == ffha_pkg::REQ_REALLOC && !has)) begin
            if (s != 0) begin
                if (!take_block(s, h)) begin
                    res.status = ffha_pkg::ST_OK;
                    res.result_addr = 12'(h + HEADER_BYTES);
                end else begin
                    res.status = ffha_pkg::ST_OOM;
                end
            end
        end else if (kind == ffha_pkg::REQ_FREE) begin
            if (ok_addr) give_back(p);
        end else if (kind == ffha_pkg::REQ_REALLOC && ok_addr) begin
            if (s == 0) begin
                give_back(p);
            end else if (hdr_size[p] >= s) begin
                shape_block(s, p);
                res.status = ffha_pkg::ST_OK;
                res.result_addr = 12'(p + HEADER_BYTES);
            end else begin
                old = hdr_size[p];
                if (!take_block(s, h)) begin
                    give_back(p);
                    res.status = ffha_pkg::ST_OK;
                    res.result_addr = 12'(h + HEADER_BYTES);
                    res.copy_src = 12'(a);
                    res.copy_len = 12'(old);
                end else begin
                    res.status = ffha_pkg::ST_OOM;
                end
            end
        end
        return res;
    endfunction

    // send one request word, predict it and keep the live list current
    task automatic send_request(input logic [1:0] kind, input int s, input int a,
                                input bit has, output t_result res);
        int idx[$];
        bit live;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_req_type <= kind;
        i_req_size <= 12'(s);
        i_addr     <= 12'(a);
        i_has_addr <= has;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        res = heap_response(kind, s, a, has);
        pending_results.push_back(res);
        idx = live_blocks.find_first_index(x) with (x == a);
        live = has && idx.size() != 0;
        if (kind == ffha_pkg::REQ_ALLOC || (kind == ffha_pkg::REQ_REALLOC && !has)) begin
            if (res.status == ffha_pkg::ST_OK) live_blocks.push_back(int'(res.result_addr));
        end else if (kind == ffha_pkg::REQ_FREE && live) begin
            live_blocks.delete(idx[0]);
        end else if (kind == ffha_pkg::REQ_REALLOC && live) begin
            if (s == 0) live_blocks.delete(idx[0]);
            else if (res.status == ffha_pkg::ST_OK) live_blocks[idx[0]] = int'(res.result_addr);
        end
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_limit(input int value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= 13'(value);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        heap_limit = value;
    endtask

    // result word checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report("result word with nothing expected");
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status)
                    report($sformatf("status %0d, want %0d", o_status, want.status));
                if (o_result_addr !== want.result_addr)
                    report($sformatf("result_addr %0d, want %0d",
                                     o_result_addr, want.result_addr));
                if (o_copy_src !== want.copy_src)
                    report($sformatf("copy_src %0d, want %0d", o_copy_src, want.copy_src));
                if (o_copy_len !== want.copy_len)
                    report($sformatf("copy_len %0d, want %0d", o_copy_len, want.copy_len));
            end
        end
    end

    // receiver back-pressure
    initial begin
        forever begin
            if (quiet) begin
                i_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                i_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
        end
    end

    task automatic test_alloc_edges();
        t_result r;
        send_request(ffha_pkg::REQ_ALLOC, 0, 0, 1'b0, r);
        send_request(ffha_pkg::REQ_ALLOC, 4095, 4095, 1'b1, r);
        send_request(ffha_pkg::REQ_ALLOC, 16, 0, 1'b0, r);
        send_request(ffha_pkg::REQ_ALLOC, 100, 0, 1'b0, r);
        send_request(ffha_pkg::REQ_ALLOC, 16, 0, 1'b0, r);
        send_request(REQ_UNKNOWN, 4095, 4095, 1'b1, r);
        send_request(ffha_pkg::REQ_FREE, 0, 0, 1'b0, r);
        send_request(ffha_pkg::REQ_FREE, 0, 0, 1'b1, r);
        send_request(ffha_pkg::REQ_FREE, 0, 4095, 1'b1, r);
        wait_idle();
    endtask

    task automatic test_merge_and_realloc();
        t_result r;
        int a0;
        int a1;
        int a2;
        a0 = live_blocks[0];
        a1 = live_blocks[1];
        a2 = live_blocks[2];
        send_request(ffha_pkg::REQ_FREE, 0, a0, 1'b1, r);        // plain push
        send_request(ffha_pkg::REQ_FREE, 0, a1, 1'b1, r);        // merges with the left block
        send_request(ffha_pkg::REQ_ALLOC, 8, 0, 1'b0, r);        // first fit with a split
        send_request(ffha_pkg::REQ_REALLOC, 8, a2, 1'b1, r);     // shrink in place
        send_request(ffha_pkg::REQ_REALLOC, 300, a2, 1'b1, r);   // move and copy
        send_request(ffha_pkg::REQ_REALLOC, 20, 0, 1'b0, r);     // null acts as allocate
        send_request(ffha_pkg::REQ_REALLOC, 0, live_blocks[0], 1'b1, r);
        send_request(ffha_pkg::REQ_REALLOC, 50, 5, 1'b1, r);     // bad address
        wait_idle();
    endtask

    task automatic test_limit_extremes();
        t_result r;
        write_limit(0);
        send_request(ffha_pkg::REQ_ALLOC, 4000, 0, 1'b0, r);
        send_request(ffha_pkg::REQ_REALLOC, 4000, live_blocks[0], 1'b1, r);  // failed move
        wait_idle();
        write_limit(8191);
        send_request(ffha_pkg::REQ_ALLOC, 2730, 0, 1'b0, r);
        send_request(ffha_pkg::REQ_ALLOC, 1365, 0, 1'b0, r);
        wait_idle();
        write_limit(4096);
    endtask

    task automatic random_request();
        t_result r;
        int pick;
        int s;
        int a;
        pick = $urandom_range(0, 99);
        s = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(1, 120);
        if (live_blocks.size() == 0 && pick >= 45 && pick < 88) pick = 0;
        if (pick < 45) begin
            send_request(ffha_pkg::REQ_ALLOC, s, $urandom_range(0, 4095), 1'($urandom), r);
        end else if (pick < 73) begin
            a = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
            send_request(ffha_pkg::REQ_FREE, $urandom_range(0, 4095), a, 1'b1, r);
        end else if (pick < 88) begin
            a = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
            if ($urandom_range(0, 7) == 0) s = 0;
            else s = $urandom_range(1, 250);
            send_request(ffha_pkg::REQ_REALLOC, s, a, 1'b1, r);
        end else if (pick < 92) begin
            send_request(ffha_pkg::REQ_REALLOC, s, $urandom_range(0, 4095), 1'b0, r);
        end else if (pick < 97) begin
            a = $urandom_range(0, 4095);
            if (a >= HEADER_BYTES && a - HEADER_BYTES < heap_top) a = $urandom_range(0, 31);
            send_request($urandom_range(0, 1) ? ffha_pkg::REQ_FREE : ffha_pkg::REQ_REALLOC,
                         s, a, 1'b1, r);
        end else begin
            send_request(REQ_UNKNOWN, $urandom_range(0, 4095), $urandom_range(0, 4095),
                         1'($urandom), r);
        end
    endtask

    task automatic test_random_phase(input int limit);
        write_limit(limit);
        repeat (ITEMS_PHASE) random_request();
        wait_idle();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_alloc_edges();
        test_merge_and_realloc();
        test_limit_extremes();
        test_random_phase(4096);
        test_random_phase(1200);
        test_random_phase(0);
        test_random_phase(8191);
        test_random_phase(4095);
        quiet = 1'b1;
        test_random_phase(4096);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
`default_nettype wire

// File: filelist.f
+incdir+design
design/ffha_pkg.sv
design/first_fit_heap_allocator_unit.sv
bench/tb_first_fit_heap_allocator_unit.sv
